FILE: sv/bffa_pkg.sv
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared constants, types and helpers of the first-free bitmap allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

	localparam int MAP_BITS  = 65536;
	localparam int WORD_BITS = 32;
	localparam int MAP_WORDS = MAP_BITS / WORD_BITS;
	localparam int ADDR_W    = $clog2(MAP_WORDS);
	localparam int PTR_W     = ADDR_W + 1;
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int POS_W     = $clog2(MAP_BITS);
	localparam int LIMIT_W   = 17;
	localparam int IDX_W     = 32;
	localparam int CFG_ADDR_W = 1;

	localparam logic [CFG_ADDR_W-1:0] REG_BIT_LIMIT  = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_FIRST_ZONE = 1'b1;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	localparam logic [LIMIT_W-1:0] BIT_LIMIT_RST  = LIMIT_W'(MAP_BITS);
	localparam logic [IDX_W-1:0]   FIRST_ZONE_RST = IDX_W'(1);

	typedef logic [WORD_BITS-1:0] word_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		word_t             wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	function automatic logic [BIT_W-1:0] first_zero(input word_t w);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i]) begin
				r = BIT_W'(i);
			end
		end
		return r;
	endfunction

endpackage

FILE: sv/bffa_mem.sv
// ----------------------------------------------------------------------------
// bffa_mem
// Bitmap word store with a registered read and a clearing sweep
// after reset that leaves only the reserved bit set.
// ----------------------------------------------------------------------------
module bffa_mem (
	input  logic               clk,
	input  logic               arst_n,
	input  bffa_pkg::mem_req_t req,
	output bffa_pkg::word_t    rdata,
	output logic               ready
);

	bffa_pkg::word_t                bits_q [bffa_pkg::MAP_WORDS];
	bffa_pkg::word_t                rdata_q;
	logic [bffa_pkg::PTR_W-1:0]     clr_q;
	logic                           clr_busy;
	logic                           wr_en;
	logic [bffa_pkg::ADDR_W-1:0]    wr_addr;
	bffa_pkg::word_t                wr_data;

	assign clr_busy = (clr_q != bffa_pkg::PTR_W'(bffa_pkg::MAP_WORDS));
	assign ready    = !clr_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clr_busy) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_comb begin
		if (clr_busy) begin
			wr_en   = 1'b1;
			wr_addr = clr_q[bffa_pkg::ADDR_W-1:0];
			wr_data = (clr_q == '0) ? bffa_pkg::WORD_BITS'(1) : '0;
		end else begin
			wr_en   = req.we;
			wr_addr = req.waddr;
			wr_data = req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			bits_q[wr_addr] <= wr_data;
		end
		if (req.re) begin
			rdata_q <= bits_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/bitmap_first_free_allocator_unit.sv
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator_unit
// First-fit allocator over a 65536-bit map held in a word memory.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream: s_tuser is the mode (allocate or free)
// and s_tdata the external index to free. Every request returns one word on
// the m_ stream: the allocated index, or zero for no space and for frees.
// bit_limit and first_zone are written through cfg_we/cfg_addr/cfg_wdata; the user
// must write them only while the block is idle, which the block itself does not enforce.
// After reset a sweep over all 2048 map words clears the map, leaving bit 0 set as
// the reserved entry; s_tready stays low until it ends.
// An allocate scans one map word per cycle from a hint, the lowest word that
// may hold a clear bit, and ends without a read when the hint already lies
// past a full map. A free reads the word, then modifies and writes it back;
// an index that maps outside the map is answered without a memory access.
// The memory has a single port, and one request is worked at a time.
// The result sits in an output register; a new request is accepted while it
// waits. If the receiver stalls, a finished result waits until the register
// is taken.
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bffa_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [bffa_pkg::IDX_W-1:0]        cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [bffa_pkg::IDX_W-1:0]        s_tdata,   // index
	input  logic                              s_tuser,   // mode
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [bffa_pkg::IDX_W-1:0]        m_tdata    // result_index
);

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_SCAN    = 6'b000010,
		ST_COMMIT  = 6'b000100,
		ST_FREE_RD = 6'b001000,
		ST_FREE_WR = 6'b010000,
		ST_DONE    = 6'b100000
	} state_t;

	state_t                          state_q;
	logic [bffa_pkg::LIMIT_W-1:0]    bit_limit_q;
	logic [bffa_pkg::IDX_W-1:0]      first_zone_q;
	logic [bffa_pkg::PTR_W-1:0]      ptr_q;
	logic [bffa_pkg::PTR_W-1:0]      hint_q;
	logic                            valid_s1;
	logic [bffa_pkg::ADDR_W-1:0]     addr_s1;
	bffa_pkg::word_t                 word_q;
	logic [bffa_pkg::BIT_W-1:0]      bit_q;
	logic [bffa_pkg::ADDR_W-1:0]     cand_q;
	logic [bffa_pkg::POS_W-1:0]      free_pos_q;
	logic [bffa_pkg::IDX_W-1:0]      res_q;
	logic                            out_valid_q;
	logic [bffa_pkg::IDX_W-1:0]      out_data_q;

	bffa_pkg::mem_req_t              mem_req;
	bffa_pkg::word_t                 mem_rdata;
	logic                            mem_ready;

	logic                            accept;
	logic                            ptr_end;
	logic                            hit;
	logic                            free_ge;
	logic [bffa_pkg::IDX_W:0]        free_pos_w;
	logic                            free_ok;
	logic [bffa_pkg::POS_W-1:0]      cand_pos;
	logic                            cand_ok;
	logic [bffa_pkg::IDX_W-1:0]      cand_res;
	logic [bffa_pkg::ADDR_W-1:0]     free_word;
	logic                            out_load;

	bffa_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rdata  (mem_rdata),
		.ready  (mem_ready)
	);

	assign s_tready = (state_q == ST_IDLE) && mem_ready;
	assign accept   = s_tvalid && s_tready;
	assign ptr_end  = (ptr_q == bffa_pkg::PTR_W'(bffa_pkg::MAP_WORDS));
	assign hit      = valid_s1 && (~mem_rdata != '0);

	assign free_ge    = (s_tdata >= first_zone_q);
	assign free_pos_w = {1'b0, s_tdata - first_zone_q} + 1'b1;
	assign free_ok    = free_ge && (free_pos_w < (bffa_pkg::IDX_W + 1)'(bffa_pkg::MAP_BITS));
	assign free_word  = free_pos_q[bffa_pkg::POS_W-1:bffa_pkg::BIT_W];

	assign cand_pos = {cand_q, bit_q};
	assign cand_ok  = (bffa_pkg::LIMIT_W'(cand_pos) < bit_limit_q);
	assign cand_res = bffa_pkg::IDX_W'(cand_pos) + first_zone_q - 1'b1;

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	always_comb begin
		mem_req = '0;
		case (state_q)
			ST_SCAN: begin
				mem_req.re    = !ptr_end;
				mem_req.raddr = ptr_q[bffa_pkg::ADDR_W-1:0];
			end
			ST_COMMIT: begin
				mem_req.we    = cand_ok;
				mem_req.waddr = cand_q;
				mem_req.wdata = word_q | (bffa_pkg::WORD_BITS'(1) << bit_q);
			end
			ST_FREE_RD: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = free_word;
			end
			ST_FREE_WR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = free_word;
				mem_req.wdata = mem_rdata &
					~(bffa_pkg::WORD_BITS'(1) << free_pos_q[bffa_pkg::BIT_W-1:0]);
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_limit_q  <= bffa_pkg::BIT_LIMIT_RST;
			first_zone_q <= bffa_pkg::FIRST_ZONE_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				bffa_pkg::REG_BIT_LIMIT:  bit_limit_q  <= cfg_wdata[bffa_pkg::LIMIT_W-1:0];
				bffa_pkg::REG_FIRST_ZONE: first_zone_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ptr_q    <= '0;
			hint_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_SCAN) && !ptr_end && !hit;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser == bffa_pkg::MODE_ALLOC) begin
							ptr_q   <= hint_q;
							state_q <= ST_SCAN;
						end else if (free_ok) begin
							state_q <= ST_FREE_RD;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (!ptr_end) begin
						ptr_q <= ptr_q + 1'b1;
					end
					if (hit) begin
						state_q <= ST_COMMIT;
					end else if (ptr_end && !valid_s1) begin
						hint_q  <= ptr_q;
						state_q <= ST_DONE;
					end
				end
				ST_COMMIT: begin
					hint_q  <= {1'b0, cand_q};
					state_q <= ST_DONE;
				end
				ST_FREE_RD: begin
					state_q <= ST_FREE_WR;
				end
				ST_FREE_WR: begin
					if ({1'b0, free_word} < hint_q) begin
						hint_q <= {1'b0, free_word};
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= ptr_q[bffa_pkg::ADDR_W-1:0];
		if (hit) begin
			word_q <= mem_rdata;
			bit_q  <= bffa_pkg::first_zero(mem_rdata);
			cand_q <= addr_s1;
		end
		if (accept) begin
			free_pos_q <= free_pos_w[bffa_pkg::POS_W-1:0];
			res_q      <= '0;
		end else if (state_q == ST_COMMIT) begin
			res_q <= (cand_ok && (cand_pos != '0)) ? cand_res : '0;
		end
		if (out_load) begin
			out_data_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_s1_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q == ST_SCAN))
		else $error("scan data stage valid outside the scan");

	a_hint_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		hint_q <= bffa_pkg::PTR_W'(bffa_pkg::MAP_WORDS))
		else $error("scan hint beyond the map");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("accepted request left no work");

	a_free_writes_back: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FREE_RD) |=> (mem_req.we && (state_q == ST_FREE_WR)))
		else $error("free read not followed by write-back");

	a_no_access_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_IDLE) || (state_q == ST_DONE)) |-> (!mem_req.we && !mem_req.re))
		else $error("memory access while no request is at work");

endmodule
